// ----- hw/rtl/scdt_pkg.sv -----
// shared types and constants of the seconds countdown timer
`timescale 1ns / 1ps

package scdt_pkg;

    // command codes carried in the mode field
    typedef enum logic [3:0] {
        CMD_INIT      = 4'd0,
        CMD_SET       = 4'd1,
        CMD_START     = 4'd2,
        CMD_PAUSE     = 4'd3,
        CMD_RESUME    = 4'd4,
        CMD_STOP      = 4'd5,
        CMD_RESET     = 4'd6,
        CMD_TICK      = 4'd7,
        CMD_INCREMENT = 4'd8,
        CMD_DECREMENT = 4'd9
    } cmd_t;

    // run state machine, one-hot
    typedef enum logic [3:0] {
        ST_STOPPED  = 4'b0001,
        ST_RUNNING  = 4'b0010,
        ST_PAUSED   = 4'b0100,
        ST_FINISHED = 4'b1000
    } run_fsm_t;

    // run state codes as reported on the result
    localparam logic [1:0] RUN_CODE_STOPPED  = 2'd0;
    localparam logic [1:0] RUN_CODE_RUNNING  = 2'd1;
    localparam logic [1:0] RUN_CODE_PAUSED   = 2'd2;
    localparam logic [1:0] RUN_CODE_FINISHED = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_TICKS_PER_SECOND = 2'd0;
    localparam logic [1:0] CFG_MAX_SECONDS      = 2'd1;
    localparam logic [1:0] CFG_DEFAULT_SECONDS  = 2'd2;

    // configuration reset values
    localparam logic [15:0] TICKS_PER_SECOND_RST = 16'd1000;
    localparam logic [7:0]  MAX_SECONDS_RST      = 8'd99;
    localparam logic [7:0]  DEFAULT_SECONDS_RST  = 8'd0;

    // configuration register contents
    typedef struct packed {
        logic [15:0] ticks_per_second;
        logic [7:0]  max_seconds;
        logic [7:0]  default_seconds;
    } cfg_t;

    // timer state kept between commands
    typedef struct packed {
        logic [7:0]  remaining;
        logic [7:0]  restart;
        logic [15:0] tick_count;
        run_fsm_t    fsm;
        logic        alarm;
    } timer_t;

    // one result item
    typedef struct packed {
        logic       display_refresh;
        logic       alarm_active;
        logic [1:0] run_state;
        logic [7:0] start_seconds;
        logic [7:0] current_seconds;
    } result_t;

endpackage

// ----- hw/rtl/seconds_countdown_timer_core.sv -----
// top level of the seconds countdown timer with tick prescaler
`timescale 1ns / 1ps

// Countdown timer driven by a stream of commands, one result per command.
// The block takes one command in every cycle while the result side does not
// stall; a command passes through the input register, then the result
// register, where its result can be taken, and the combinational command
// logic that sits between the two registers updates the timer
// state. Configuration writes are taken at once and apply from the next
// command; they are meant to be issued only while no command is in flight.
module seconds_countdown_timer_core (
    input  logic        aclk,
    input  logic        aresetn,
    // command stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // mode[3:0], seconds_value[11:4], zeros[15:12]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // current_seconds[7:0], start_seconds[15:8],
                                   // run_state[17:16], alarm_active[18],
                                   // display_refresh[19], zeros[23:20]
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import scdt_pkg::*;

    cfg_t    cfg;
    timer_t  timer_reg;
    timer_t  timer_next;
    result_t res_next;
    result_t res_reg;
    logic    in_valid_reg;
    logic [3:0] mode_reg;
    logic [7:0] value_reg;
    logic    out_valid_reg;
    logic    advance;

    assign cfg_ready = 1'b1;

    scdt_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // command moves on when the result register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            mode_reg  <= s_tdata[3:0];
            value_reg <= s_tdata[11:4];
        end
    end

    scdt_cmd_logic u_cmd (
        .cfg           (cfg),
        .cur           (timer_reg),
        .mode          (mode_reg),
        .seconds_value (value_reg),
        .nxt           (timer_next),
        .res           (res_next)
    );

    // timer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timer_reg.remaining  <= DEFAULT_SECONDS_RST;
            timer_reg.restart    <= DEFAULT_SECONDS_RST;
            timer_reg.tick_count <= '0;
            timer_reg.fsm        <= ST_STOPPED;
            timer_reg.alarm      <= 1'b0;
        end else if (advance) begin
            timer_reg <= timer_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, res_reg};

    // finished only ever holds with zero seconds left
    a_finished_at_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        timer_reg.fsm == ST_FINISHED |-> timer_reg.remaining == 8'd0)
        else $error("finished state with seconds remaining");

    // alarm sounds only when finished or stopped after finishing
    a_alarm_state: assert property (@(posedge aclk) disable iff (!aresetn)
        timer_reg.alarm |-> (timer_reg.fsm == ST_FINISHED || timer_reg.fsm == ST_STOPPED))
        else $error("alarm on while running or paused");

    // a command that moves on leaves a result waiting
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("command processed without a result");

    // the state changes only when a command is processed
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(timer_reg))
        else $error("timer state changed without a command");

endmodule

// ----- hw/rtl/scdt_cfg_regs.sv -----
// configuration register file of the countdown timer
`timescale 1ns / 1ps

module scdt_cfg_regs (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    input  logic [1:0]    cfg_index,
    input  logic [15:0]   cfg_data,
    output scdt_pkg::cfg_t cfg
);
    import scdt_pkg::*;

    cfg_t cfg_reg;

    // register writes, indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ticks_per_second <= TICKS_PER_SECOND_RST;
            cfg_reg.max_seconds      <= MAX_SECONDS_RST;
            cfg_reg.default_seconds  <= DEFAULT_SECONDS_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TICKS_PER_SECOND: cfg_reg.ticks_per_second <= cfg_data;
                CFG_MAX_SECONDS:      cfg_reg.max_seconds      <= cfg_data[7:0];
                CFG_DEFAULT_SECONDS:  cfg_reg.default_seconds  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/scdt_cmd_logic.sv -----
// command decode and next-state logic of the countdown timer
`timescale 1ns / 1ps

module scdt_cmd_logic (
    input  scdt_pkg::cfg_t    cfg,
    input  scdt_pkg::timer_t  cur,
    input  logic [3:0]        mode,
    input  logic [7:0]        seconds_value,
    output scdt_pkg::timer_t  nxt,
    output scdt_pkg::result_t res
);
    import scdt_pkg::*;

    logic [15:0] tick_inc;
    logic [7:0]  remaining_dec;
    logic [7:0]  remaining_inc;
    logic [7:0]  set_value;
    logic        remaining_nz;
    logic        refresh;

    assign tick_inc      = cur.tick_count + 16'd1;
    assign remaining_dec = cur.remaining - 8'd1;
    assign remaining_inc = cur.remaining + 8'd1;
    assign remaining_nz  = (cur.remaining != 8'd0);
    assign set_value     = (seconds_value > cfg.max_seconds) ? cfg.max_seconds : seconds_value;

    // command decode
    always_comb begin
        nxt     = cur;
        refresh = 1'b0;
        case (mode)
            CMD_INIT: begin
                nxt.remaining  = cfg.default_seconds;
                nxt.restart    = cfg.default_seconds;
                nxt.tick_count = '0;
                nxt.fsm        = ST_STOPPED;
                nxt.alarm      = 1'b0;
                refresh        = 1'b1;
            end
            CMD_SET: begin
                nxt.remaining  = set_value;
                nxt.restart    = set_value;
                nxt.tick_count = '0;
                nxt.fsm        = ST_STOPPED;
                nxt.alarm      = 1'b0;
                refresh        = 1'b1;
            end
            CMD_START: begin
                if (remaining_nz) begin
                    nxt.fsm   = ST_RUNNING;
                    nxt.alarm = 1'b0;
                end
            end
            CMD_PAUSE: begin
                if (cur.fsm == ST_RUNNING) begin
                    nxt.fsm = ST_PAUSED;
                end
            end
            CMD_RESUME: begin
                if (cur.fsm == ST_PAUSED && remaining_nz) begin
                    nxt.fsm = ST_RUNNING;
                end
            end
            CMD_STOP: begin
                nxt.fsm        = ST_STOPPED;
                nxt.tick_count = '0;
            end
            CMD_RESET: begin
                nxt.remaining  = cur.restart;
                nxt.tick_count = '0;
                nxt.fsm        = ST_STOPPED;
                nxt.alarm      = 1'b0;
                refresh        = 1'b1;
            end
            CMD_TICK: begin
                if (cur.fsm == ST_RUNNING) begin
                    nxt.tick_count = tick_inc;
                    // one second elapsed
                    if (tick_inc >= cfg.ticks_per_second) begin
                        nxt.tick_count = '0;
                        if (remaining_nz) begin
                            nxt.remaining = remaining_dec;
                            refresh       = 1'b1;
                        end
                        if (!remaining_nz || remaining_dec == 8'd0) begin
                            nxt.fsm   = ST_FINISHED;
                            nxt.alarm = 1'b1;
                        end
                    end
                end
            end
            CMD_INCREMENT: begin
                if (cur.remaining < cfg.max_seconds) begin
                    nxt.remaining  = remaining_inc;
                    nxt.restart    = remaining_inc;
                    nxt.tick_count = '0;
                    nxt.alarm      = 1'b0;
                    refresh        = 1'b1;
                    if (cur.fsm == ST_FINISHED) begin
                        nxt.fsm = ST_STOPPED;
                    end
                end
            end
            CMD_DECREMENT: begin
                if (remaining_nz) begin
                    nxt.remaining  = remaining_dec;
                    nxt.restart    = remaining_dec;
                    nxt.tick_count = '0;
                    nxt.alarm      = 1'b0;
                    refresh        = 1'b1;
                    if (cur.fsm == ST_FINISHED) begin
                        nxt.fsm = ST_STOPPED;
                    end
                end
            end
            default: ;
        endcase
    end

    // result fields from the updated state
    always_comb begin
        res.current_seconds = nxt.remaining;
        res.start_seconds   = nxt.restart;
        res.alarm_active    = nxt.alarm;
        res.display_refresh = refresh;
        case (nxt.fsm)
            ST_RUNNING:  res.run_state = RUN_CODE_RUNNING;
            ST_PAUSED:   res.run_state = RUN_CODE_PAUSED;
            ST_FINISHED: res.run_state = RUN_CODE_FINISHED;
            default:     res.run_state = RUN_CODE_STOPPED;
        endcase
    end

endmodule

// ----- bench/seconds_countdown_timer_core_tb.sv -----
// self-checking testbench of the seconds countdown timer core: directed table, then random phases
`timescale 1ns / 1ps

module seconds_countdown_timer_core_tb;
    import scdt_pkg::*;

    localparam int         QUIET_LIMIT   = 500;
    localparam int         RANDOM_PHASES = 6;
    localparam int         PHASE_ITEMS   = 300;
    localparam logic [3:0] MODE_SPARE_LO = 4'd10;
    localparam logic [3:0] MODE_SPARE_HI = 4'd15;

    // one row of the directed table
    typedef struct {
        bit          is_cfg;  // register write instead of a command
        logic [3:0]  code;    // command, or register index for a write
        logic [15:0] value;   // seconds value, or register data
        bit          typed;   // want holds a hand-written expectation
        result_t     want;
    } plan_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [15:0] s_tdata   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [23:0] m_tdata;
    logic        cfg_ready;

    always #10 aclk = ~aclk;

    seconds_countdown_timer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the registers and the timer state
    logic [15:0] tps_reg      = TICKS_PER_SECOND_RST;
    logic [7:0]  max_reg      = MAX_SECONDS_RST;
    logic [7:0]  dflt_reg     = DEFAULT_SECONDS_RST;
    logic [7:0]  secs_left    = DEFAULT_SECONDS_RST;
    logic [7:0]  restart_secs = DEFAULT_SECONDS_RST;
    logic [15:0] prescale     = '0;
    logic [1:0]  run_code     = RUN_CODE_STOPPED;
    logic        alarm        = 1'b0;

    result_t pending_results[$];
    int      mismatch_count = 0;
    int      quiet_cycles   = 0;
    int      stall_left     = 0;
    bit      idle_en        = 1'b1;

    // apply one command to the predicted timer and return its result
    function automatic result_t advance_timer(input logic [3:0] mode, input logic [7:0] val);
        result_t r;
        logic    refresh;
        refresh = 1'b0;
        case (mode)
            CMD_INIT: begin
                secs_left    = dflt_reg;
                restart_secs = dflt_reg;
                prescale     = '0;
                run_code     = RUN_CODE_STOPPED;
                alarm        = 1'b0;
                refresh      = 1'b1;
            end
            CMD_SET: begin
                secs_left    = (val > max_reg) ? max_reg : val;
                restart_secs = secs_left;
                prescale     = '0;
                run_code     = RUN_CODE_STOPPED;
                alarm        = 1'b0;
                refresh      = 1'b1;
            end
            CMD_START: begin
                if (secs_left != 8'd0) begin
                    run_code = RUN_CODE_RUNNING;
                    alarm    = 1'b0;
                end
            end
            CMD_PAUSE: begin
                if (run_code == RUN_CODE_RUNNING) run_code = RUN_CODE_PAUSED;
            end
            CMD_RESUME: begin
                if (run_code == RUN_CODE_PAUSED && secs_left != 8'd0) run_code = RUN_CODE_RUNNING;
            end
            CMD_STOP: begin
                // alarm keeps sounding
                run_code = RUN_CODE_STOPPED;
                prescale = '0;
            end
            CMD_RESET: begin
                secs_left = restart_secs;
                prescale  = '0;
                run_code  = RUN_CODE_STOPPED;
                alarm     = 1'b0;
                refresh   = 1'b1;
            end
            CMD_TICK: begin
                if (run_code == RUN_CODE_RUNNING) begin
                    prescale = prescale + 16'd1;
                    if (prescale >= tps_reg) begin
                        prescale = '0;
                        if (secs_left != 8'd0) begin
                            secs_left = secs_left - 8'd1;
                            refresh   = 1'b1;
                        end
                        if (secs_left == 8'd0) begin
                            run_code = RUN_CODE_FINISHED;
                            alarm    = 1'b1;
                        end
                    end
                end
            end
            CMD_INCREMENT, CMD_DECREMENT: begin
                if ((mode == CMD_INCREMENT) ? (secs_left < max_reg) : (secs_left != 8'd0)) begin
                    secs_left    = (mode == CMD_INCREMENT) ? secs_left + 8'd1 : secs_left - 8'd1;
                    restart_secs = secs_left;
                    prescale     = '0;
                    alarm        = 1'b0;
                    refresh      = 1'b1;
                    if (run_code == RUN_CODE_FINISHED) run_code = RUN_CODE_STOPPED;
                end
            end
            default: ;
        endcase
        r.current_seconds = secs_left;
        r.start_seconds   = restart_secs;
        r.run_state       = run_code;
        r.alarm_active    = alarm;
        r.display_refresh = refresh;
        return r;
    endfunction

    function automatic plan_row_t cmd_row(input logic [3:0] mode, input logic [7:0] val);
        plan_row_t row;
        row.is_cfg = 1'b0;
        row.code   = mode;
        row.value  = {8'h00, val};
        row.typed  = 1'b0;
        row.want   = '0;
        return row;
    endfunction

    function automatic plan_row_t chk_row(input logic [3:0] mode, input logic [7:0] val,
                                          input logic [7:0] cur, input logic [7:0] start,
                                          input logic [1:0] run, input logic buzz,
                                          input logic refr);
        plan_row_t row;
        row                      = cmd_row(mode, val);
        row.typed                = 1'b1;
        row.want.current_seconds = cur;
        row.want.start_seconds   = start;
        row.want.run_state       = run;
        row.want.alarm_active    = buzz;
        row.want.display_refresh = refr;
        return row;
    endfunction

    function automatic plan_row_t cfg_row(input logic [1:0] idx, input logic [15:0] data);
        plan_row_t row;
        row        = cmd_row(4'd0, 8'd0);
        row.is_cfg = 1'b1;
        row.code   = {2'b00, idx};
        row.value  = data;
        return row;
    endfunction

    // one command transfer, with an optional gap before it
    task automatic push_cmd(input logic [3:0] mode, input logic [7:0] val,
                            input bit typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = (idle_en && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, val, mode};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        predicted = advance_timer(mode, val);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // stop sending and wait until every result is back
    task automatic wait_results_done;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        case (idx)
            CFG_TICKS_PER_SECOND: tps_reg  = data;
            CFG_MAX_SECONDS:      max_reg  = data[7:0];
            CFG_DEFAULT_SECONDS:  dflt_reg = data[7:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result side back-pressure in random bursts
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (idle_en && $urandom_range(0, 5) == 0) begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[19:0];
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $error("result with no command pending: m_tdata %h", m_tdata);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (got.current_seconds !== want.current_seconds)
                        $error("current_seconds expected %0d got %0d",
                               want.current_seconds, got.current_seconds);
                    if (got.start_seconds !== want.start_seconds)
                        $error("start_seconds expected %0d got %0d",
                               want.start_seconds, got.start_seconds);
                    if (got.run_state !== want.run_state)
                        $error("run_state expected %0d got %0d",
                               want.run_state, got.run_state);
                    if (got.alarm_active !== want.alarm_active)
                        $error("alarm_active expected %0d got %0d",
                               want.alarm_active, got.alarm_active);
                    if (got.display_refresh !== want.display_refresh)
                        $error("display_refresh expected %0d got %0d",
                               want.display_refresh, got.display_refresh);
                end
            end
        end
    end

    // cycles with no transfer on any channel
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stimulus
        plan_row_t  plan[$];
        int         counted;
        int         sent;
        int         pick;
        logic [3:0] mode;
        logic [7:0] val;

        // register defaults: one second per 1000 ticks, ceiling 99, init value 0
        plan.push_back(chk_row(CMD_INIT, 8'd0, 8'd0, 8'd0, RUN_CODE_STOPPED, 1'b0, 1'b1));
        // start with nothing left is ignored
        plan.push_back(chk_row(CMD_START, 8'd0, 8'd0, 8'd0, RUN_CODE_STOPPED, 1'b0, 1'b0));
        // set above the ceiling clamps
        plan.push_back(chk_row(CMD_SET, 8'd255, 8'd99, 8'd99, RUN_CODE_STOPPED, 1'b0, 1'b1));
        plan.push_back(chk_row(CMD_SET, 8'd0, 8'd0, 8'd0, RUN_CODE_STOPPED, 1'b0, 1'b1));
        // decrement at zero is ignored
        plan.push_back(chk_row(CMD_DECREMENT, 8'd0, 8'd0, 8'd0, RUN_CODE_STOPPED, 1'b0, 1'b0));
        plan.push_back(cmd_row(CMD_INCREMENT, 8'd0));
        plan.push_back(cmd_row(MODE_SPARE_HI, 8'hFF));
        plan.push_back(cmd_row(CMD_TICK, 8'd0));
        plan.push_back(cmd_row(CMD_PAUSE, 8'd0));
        plan.push_back(cmd_row(CMD_RESUME, 8'd0));
        plan.push_back(cmd_row(CMD_START, 8'd0));
        plan.push_back(cmd_row(CMD_TICK, 8'd0));
        plan.push_back(cmd_row(CMD_PAUSE, 8'd0));
        plan.push_back(cmd_row(CMD_TICK, 8'd0));
        // paused at zero, so resume is ignored
        plan.push_back(cmd_row(CMD_DECREMENT, 8'd0));
        plan.push_back(cmd_row(CMD_RESUME, 8'd0));
        plan.push_back(cmd_row(CMD_STOP, 8'd0));
        plan.push_back(cmd_row(CMD_RESET, 8'd0));
        // zero prescale: every running tick is one second
        plan.push_back(cfg_row(CFG_TICKS_PER_SECOND, 16'd0));
        plan.push_back(cfg_row(CFG_MAX_SECONDS, 16'd255));
        plan.push_back(cfg_row(CFG_DEFAULT_SECONDS, 16'd255));
        plan.push_back(chk_row(CMD_INIT, 8'd0, 8'd255, 8'd255, RUN_CODE_STOPPED, 1'b0, 1'b1));
        plan.push_back(cmd_row(CMD_INCREMENT, 8'd0));
        plan.push_back(cmd_row(CMD_SET, 8'd2));
        plan.push_back(cmd_row(CMD_START, 8'd0));
        plan.push_back(cmd_row(CMD_TICK, 8'd0));
        // running at zero: the next second finishes without a refresh
        plan.push_back(cmd_row(CMD_DECREMENT, 8'd0));
        plan.push_back(cmd_row(CMD_TICK, 8'd0));
        plan.push_back(cmd_row(CMD_INCREMENT, 8'd0));
        plan.push_back(cmd_row(CMD_START, 8'd0));
        plan.push_back(cmd_row(CMD_TICK, 8'd0));
        // stop leaves the alarm on
        plan.push_back(cmd_row(CMD_STOP, 8'd0));
        // largest prescale, ceiling of zero
        plan.push_back(cfg_row(CFG_TICKS_PER_SECOND, 16'hFFFF));
        plan.push_back(cfg_row(CFG_MAX_SECONDS, 16'd0));
        plan.push_back(cfg_row(CFG_DEFAULT_SECONDS, 16'd0));
        plan.push_back(chk_row(CMD_SET, 8'd200, 8'd0, 8'd0, RUN_CODE_STOPPED, 1'b0, 1'b1));

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                wait_results_done();
                write_reg(plan[i].code[1:0], plan[i].value);
            end else begin
                push_cmd(plan[i].code, plan[i].value[7:0], plan[i].typed, plan[i].want);
            end
        end

        // random phases, each under its own register setting
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_results_done();
            case ($urandom_range(0, 7))
                0:       write_reg(CFG_TICKS_PER_SECOND, 16'd0);
                1:       write_reg(CFG_TICKS_PER_SECOND, 16'hFFFF);
                2:       write_reg(CFG_TICKS_PER_SECOND, 16'($urandom));
                default: write_reg(CFG_TICKS_PER_SECOND, 16'($urandom_range(1, 4)));
            endcase
            case ($urandom_range(0, 3))
                0:       write_reg(CFG_MAX_SECONDS, 16'd255);
                1:       write_reg(CFG_MAX_SECONDS, 16'($urandom_range(0, 255)));
                default: write_reg(CFG_MAX_SECONDS, 16'($urandom_range(2, 12)));
            endcase
            write_reg(CFG_DEFAULT_SECONDS, 16'($urandom_range(0, 255)));

            counted = 0;
            sent    = 0;
            while (counted < PHASE_ITEMS) begin
                // the last phase runs without any idling
                if (sent % 64 == 0)
                    idle_en = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
                // mostly ticks so that countdowns run out
                pick = $urandom_range(0, 99);
                if (pick < 40)      mode = CMD_TICK;
                else if (pick < 50) mode = CMD_START;
                else if (pick < 56) mode = CMD_SET;
                else if (pick < 61) mode = CMD_PAUSE;
                else if (pick < 66) mode = CMD_RESUME;
                else if (pick < 69) mode = CMD_STOP;
                else if (pick < 72) mode = CMD_RESET;
                else if (pick < 74) mode = CMD_INIT;
                else if (pick < 82) mode = CMD_INCREMENT;
                else if (pick < 90) mode = CMD_DECREMENT;
                else if (pick < 94) mode = 4'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
                else                mode = CMD_TICK;
                val = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 8));
                push_cmd(mode, val, 1'b0, '0);
                sent++;
                if (mode <= CMD_DECREMENT) counted++;
            end
        end

        wait_results_done();
        repeat (4) @(posedge aclk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
